>>> hw/rtl/shq_pkg.sv
`timescale 1ns / 1ps
// shq_pkg: shared types, codes and defaults for the shifting record queue
// no dependencies; used by shq_ctrl, shq_dpath and the top level

package shq_pkg;

  // default configuration
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF    = 64;

  // fixed port field widths
  localparam int KEY_W    = 64;
  localparam int SLOT_W   = 4;
  localparam int CNT_OUT_W = 5;

  // request codes
  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_DEQ  = 2'd1;
  localparam logic [1:0] REQ_DEL  = 2'd2;
  localparam logic [1:0] REQ_FIND = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [KEY_W-1:0]  food_key;
    logic [7:0]        in_duration;
    logic [23:0]       in_price;
    logic [7:0]        in_hold;
    logic [SLOT_W-1:0] slot_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [KEY_W-1:0]     out_key;
    logic [7:0]           out_duration;
    logic [23:0]          out_price;
    logic [7:0]           out_hold;
    logic [CNT_OUT_W-1:0] found_slot;
    logic                 key_found;
    logic [CNT_OUT_W-1:0] occupancy;
    logic                 is_empty;
    logic                 is_full;
  } out_word_t;

  // non-key part of one stored record
  typedef struct packed {
    logic [7:0]  duration;
    logic [23:0] price;
    logic [7:0]  hold;
  } attr_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
  } ctl_cmd_t;

endpackage

>>> hw/rtl/shifting_queue_with_remove_and_search.sv
`timescale 1ns / 1ps
// shifting_queue_with_remove_and_search: top level of the ordered record queue
// depends on shq_pkg, shq_ctrl and shq_dpath
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------
//   request  | start / busy        | in_data  (shq_pkg::in_word_t)
//   result   | out_valid (strobe)  | out_data (shq_pkg::out_word_t)
//
// a request word is taken at a rising edge with start high and busy low
// every request goes through capture, then an execute state in which the
//   record row shifts or appends and all live keys are compared at once
// the result word shows for one cycle with out_valid, in the same cycle that
//   busy drops, so a new word can be taken while the result is on the ports
// the receiver cannot stall; reset (rst_n low, synchronous) empties the queue
//   and needs no clearing pass

module shifting_queue_with_remove_and_search #(
  parameter int QUEUE_DEPTH = shq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_BITS    = shq_pkg::KEY_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  shq_pkg::in_word_t  in_data,
  output logic               out_valid,
  output shq_pkg::out_word_t out_data
);

  shq_pkg::ctl_cmd_t cmd;
  logic              accept;

  assign accept = start && !busy;

  // sequencer: idle / execute, plus the result strobe
  shq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // record row, count and result register
  shq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // an accepted word keeps the block busy and gives no result in the next cycle
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy && !out_valid))
    else $error("block not busy after accepting a word");

  // the result strobe follows an accept once the execute state has passed
  a_accept_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("result strobe missing two cycles after accept");

  // a full report always comes with the full flag
  a_full_flag : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == shq_pkg::STAT_FULL)) |-> out_data.is_full)
    else $error("full status without full flag");

  // a hit always lies below the count
  a_hit_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.key_found) |-> (out_data.found_slot < out_data.occupancy))
    else $error("found slot not below occupancy");

endmodule

>>> hw/rtl/shq_ctrl.sv
`timescale 1ns / 1ps
// shq_ctrl: request sequencer for the shifting record queue
// depends on shq_pkg (ctl_cmd_t)

module shq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output shq_pkg::ctl_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign valid_nxt   = (state_r == ST_EXEC);
  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = valid_r;
  assign cmd.capture = start && (state_r == ST_IDLE);
  assign cmd.exec    = (state_r == ST_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

>>> hw/rtl/shq_dpath.sv
`timescale 1ns / 1ps
// shq_dpath: record row, count, parallel key compare and result register
// depends on shq_pkg (words, codes, attr_t, ctl_cmd_t)

module shq_dpath #(
  parameter int QUEUE_DEPTH = shq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_BITS    = shq_pkg::KEY_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  shq_pkg::ctl_cmd_t  cmd,
  input  shq_pkg::in_word_t  in_data,
  output shq_pkg::out_word_t out_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int WW = (CW > shq_pkg::SLOT_W) ? CW : shq_pkg::SLOT_W;
  localparam int KW = shq_pkg::KEY_W;
  localparam int OW = shq_pkg::CNT_OUT_W;

  shq_pkg::in_word_t  req_r;
  shq_pkg::out_word_t out_r, out_nxt;

  logic [KEY_BITS-1:0] key_q  [QUEUE_DEPTH];
  shq_pkg::attr_t      attr_q [QUEUE_DEPTH];
  logic [KEY_BITS-1:0] key_up [QUEUE_DEPTH];
  shq_pkg::attr_t      attr_up[QUEUE_DEPTH];

  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [KEY_BITS-1:0] key_in;
  shq_pkg::attr_t      attr_in;
  logic [WW-1:0]       cnt_w, idx_w, pos_w;
  logic [AW-1:0]       pos;
  logic                is_enq, is_deq, is_del, is_find;
  logic                enq_ok, take;
  logic [CW-1:0]       found;
  logic                hit;

  // neighbor taps for the forward shift; the last cell keeps its own value
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_tap
    if (g < QUEUE_DEPTH - 1) begin : g_mid
      assign key_up[g]  = key_q[g+1];
      assign attr_up[g] = attr_q[g+1];
    end else begin : g_last
      assign key_up[g]  = key_q[g];
      assign attr_up[g] = attr_q[g];
    end
  end

  assign key_in           = req_r.food_key[KEY_BITS-1:0];
  assign attr_in.duration = req_r.in_duration;
  assign attr_in.price    = req_r.in_price;
  assign attr_in.hold     = req_r.in_hold;

  always_comb begin
    cnt_w   = WW'(cnt_r);
    idx_w   = WW'(req_r.slot_index);
    is_enq  = (req_r.req_type == shq_pkg::REQ_ENQ);
    is_deq  = (req_r.req_type == shq_pkg::REQ_DEQ);
    is_del  = (req_r.req_type == shq_pkg::REQ_DEL);
    is_find = (req_r.req_type == shq_pkg::REQ_FIND);
    enq_ok  = is_enq && (cnt_r != CW'(QUEUE_DEPTH));
    take    = (is_deq && (cnt_r != '0)) || (is_del && (cnt_r != '0) && (idx_w < cnt_w));
    pos_w   = is_del ? idx_w : '0;
    pos     = pos_w[AW-1:0];

    if (enq_ok) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (take) begin
      cnt_nxt = cnt_r - CW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end

    // first matching slot among the live entries, count when none
    found = cnt_r;
    hit   = 1'b0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if ((CW'(i) < cnt_r) && (key_q[i] == key_in)) begin
        found = CW'(i);
        hit   = 1'b1;
      end
    end

    out_nxt = '0;
    if (is_enq && !enq_ok) begin
      out_nxt.status = shq_pkg::STAT_FULL;
    end else if ((is_deq || is_del) && (cnt_r == '0)) begin
      out_nxt.status = shq_pkg::STAT_EMPTY;
    end else if (is_del && !take) begin
      out_nxt.status = shq_pkg::STAT_RANGE;
    end else begin
      out_nxt.status = shq_pkg::STAT_OK;
    end
    if (take) begin
      out_nxt.out_key      = KW'(key_q[pos]);
      out_nxt.out_duration = attr_q[pos].duration;
      out_nxt.out_price    = attr_q[pos].price;
      out_nxt.out_hold     = attr_q[pos].hold;
    end
    if (is_find) begin
      out_nxt.found_slot = OW'(found);
      out_nxt.key_found  = hit;
    end
    out_nxt.occupancy = OW'(cnt_nxt);
    out_nxt.is_empty  = (cnt_nxt == '0);
    out_nxt.is_full   = (cnt_nxt == CW'(QUEUE_DEPTH));
  end

  // count is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  // request, record row and result payload carry no reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (take && (AW'(i) >= pos) && (CW'(i + 1) < cnt_r)) begin
          key_q[i]  <= key_up[i];
          attr_q[i] <= attr_up[i];
        end else if (enq_ok && (CW'(i) == cnt_r)) begin
          key_q[i]  <= key_in;
          attr_q[i] <= attr_in;
        end
      end
    end
  end

  assign out_data = out_r;

endmodule
